### hdl/stsi_pkg.sv
`default_nettype none
package stsi_pkg;

	localparam int VAL_W  = 10;
	localparam int IDX_W  = 7;
	localparam int USED_W = 8;

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_SEARCH = 1'b1
	} cmd_t;

	typedef struct packed {
		logic             command;
		logic [VAL_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		logic              found;
		logic [IDX_W-1:0]  index;
		logic              status;
		logic [USED_W-1:0] entries_used;
	} rsp_item_t;

	// handed from one cell to the next
	typedef struct packed {
		logic [VAL_W-1:0] entry;
		logic             le;     // filled and entry <= key
		logic             lt;     // filled and entry <  key
	} link_t;

	// broadcast control to every cell
	typedef struct packed {
		logic shift;
		logic eval;
		logic search;
	} cell_ctrl_t;

	// registered per-cell result
	typedef struct packed {
		logic edge_hit;   // first cell past the key boundary
		logic eq;         // filled and entry == key
	} cell_flags_t;

endpackage
`default_nettype wire

### hdl/stsi_chan_if.sv
`default_nettype none
interface stsi_chan_if #(parameter type item_t = logic);
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/stsi_cell.sv
`default_nettype none
module stsi_cell
	import stsi_pkg::*;
#(
	parameter int POS   = 0,
	parameter int CNT_W = 8
) (
	input  wire logic             clk,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [VAL_W-1:0] key,
	input  wire logic [CNT_W-1:0] fill,
	input  wire link_t            prev,
	output link_t                 next,
	output cell_flags_t           flags
);

	logic [VAL_W-1:0] entry_q;
	cell_flags_t      flags_q;
	logic             filled;

	assign filled     = CNT_W'(POS) < fill;
	assign next.entry = entry_q;
	assign next.le    = filled && (entry_q <= key);
	assign next.lt    = filled && (entry_q < key);
	assign flags      = flags_q;

	always_ff @(posedge clk) begin
		// keep if not above key, take key at the boundary, else take the left neighbor
		if (ctrl.shift && !next.le) begin
			entry_q <= prev.le ? key : prev.entry;
		end
		if (ctrl.eval) begin
			flags_q.edge_hit <= ctrl.search ? (!next.lt && prev.lt) : (!next.le && prev.le);
			flags_q.eq       <= filled && (entry_q == key);
		end
	end

endmodule
`default_nettype wire

### hdl/stsi_enc.sv
`default_nettype none
module stsi_enc
	import stsi_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  wire cell_flags_t      flags [DEPTH],
	output logic                  found,
	output logic [IDX_W-1:0]      index
);

	// at most one cell marks the boundary
	always_comb begin
		found = 1'b0;
		index = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (flags[i].edge_hit) begin
				index = index | IDX_W'(i);
				found = found | flags[i].eq;
			end
		end
	end

endmodule
`default_nettype wire

### hdl/sorted_table_insert_search_core.sv
`default_nettype none
// Sorted table with in-order insert and search.
//
// Channels: req (sink) carries command and value; rsp (source) carries found,
// index, status and entries_used. Both transfer on valid && ready.
// Every req transfer yields exactly one rsp transfer, in order.
//
// The table is a chain of TABLE_DEPTH cells. Each cell compares its entry with
// the broadcast key and hands its entry and compare result to its right
// neighbor, so an insert shifts all larger entries up together.
//
// Steps: an item is accepted, the cells compare and shift, and the index is
// encoded into the output register by an OR tree over all cells. One item is
// in flight: a new item is accepted only after the last leaves the encode step.
// The result register parts the two sides: a new item is accepted while an
// earlier result still waits; if the receiver stalls, the finished item waits
// in the encode step until the output register frees up.
//
// Reset: fill count is cleared, rsp.valid drops, req.ready rises. Table
// contents are not cleared; only filled entries are ever looked at.
// An insert into a full table leaves it unchanged and returns status 1.
module sorted_table_insert_search_core
	import stsi_pkg::*;
#(
	parameter int TABLE_DEPTH = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	stsi_chan_if.sink   req,
	stsi_chan_if.source rsp
);

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_OP,
		S_ENC
	} state_t;

	state_t           st_q;
	logic [CNT_W-1:0] fill_q;
	logic             rsp_valid_q;
	rsp_item_t        rsp_data_q;

	logic             cmd_s1;
	logic [VAL_W-1:0] key_s1;
	logic             full_s2;

	logic             full;
	cell_ctrl_t       ctrl;
	link_t            links [TABLE_DEPTH+1];
	cell_flags_t      flags [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] edge_vec;
	logic             enc_found;
	logic [IDX_W-1:0] enc_index;

	assign full        = fill_q == CNT_W'(TABLE_DEPTH);
	assign req.ready   = st_q == S_IDLE;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.data    = rsp_data_q;

	assign ctrl.eval   = st_q == S_OP;
	assign ctrl.search = cmd_s1 == CMD_SEARCH;
	assign ctrl.shift  = (st_q == S_OP) && (cmd_s1 == CMD_INSERT) && !full;

	// virtual cell left of the first: always "not above key"
	assign links[0] = '{entry: '0, le: 1'b1, lt: 1'b1};

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		stsi_cell #(
			.POS   (g),
			.CNT_W (CNT_W)
		) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.key   (key_s1),
			.fill  (fill_q),
			.prev  (links[g]),
			.next  (links[g+1]),
			.flags (flags[g])
		);
		assign edge_vec[g] = flags[g].edge_hit;
	end

	stsi_enc #(
		.DEPTH (TABLE_DEPTH)
	) u_enc (
		.flags (flags),
		.found (enc_found),
		.index (enc_index)
	);

	// item payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1 <= req.data.command;
			key_s1 <= req.data.value;
		end
		if (st_q == S_OP) begin
			full_s2 <= full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_data_q  <= '0;
		end else begin
			// the encode step reloads the output register itself
			if (rsp_valid_q && rsp.ready && st_q != S_ENC) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (req.valid) begin
						st_q <= S_OP;
					end
				end
				S_OP: begin
					if (ctrl.shift) begin
						fill_q <= fill_q + CNT_W'(1);
					end
					st_q <= S_ENC;
				end
				S_ENC: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q             <= 1'b1;
						rsp_data_q.entries_used <= USED_W'(fill_q);
						if (cmd_s1 == CMD_SEARCH) begin
							rsp_data_q.found  <= enc_found;
							rsp_data_q.index  <= enc_found ? enc_index : '0;
							rsp_data_q.status <= 1'b0;
						end else begin
							rsp_data_q.found  <= 1'b0;
							rsp_data_q.index  <= full_s2 ? '0 : enc_index;
							rsp_data_q.status <= full_s2;
						end
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// fill count stays within the table
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count above table depth");

	// fill count only moves on a non-full insert
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(fill_q) |-> $past(ctrl.shift) && (fill_q == $past(fill_q) + CNT_W'(1)))
		else $error("fill count changed outside an insert");

	// an accepted item is evaluated in the next cycle
	a_accept_op: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> st_q == S_OP)
		else $error("accepted item not evaluated");

	// the key boundary marks at most one cell
	a_edge_one: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_ENC |-> $onehot0(edge_vec))
		else $error("more than one boundary cell");

	// a non-full insert always finds its slot
	a_ins_slot: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_ENC && cmd_s1 == CMD_INSERT && !full_s2 |-> $onehot(edge_vec))
		else $error("insert without a boundary cell");

endmodule
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import stsi_pkg::*;

	localparam int TBL_DEPTH    = 128;
	localparam int RAND_ITEMS   = 1530;
	localparam int CALM_TAIL    = 150;  // no idling on either side over the last transfers
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	// One pending request; drain_first holds it back until every result is in.
	typedef struct {
		req_item_t item;
		bit        drain_first;
	} stim_t;

	logic clk;
	logic arst_n = 1'b0;

	// Driven copies of the block inputs, known from time zero.
	logic      req_valid_q = 1'b0;
	req_item_t req_data_q  = '0;
	logic      rsp_ready_q = 1'b0;

	stsi_chan_if #(.item_t(req_item_t)) req_if ();
	stsi_chan_if #(.item_t(rsp_item_t)) rsp_if ();

	assign req_if.valid = req_valid_q;
	assign req_if.data  = req_data_q;
	assign rsp_if.ready = rsp_ready_q;

	sorted_table_insert_search_core #(
		.TABLE_DEPTH(TBL_DEPTH)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Shadow table: our own copy of the sorted entries and the fill count.
	// Only entries below shadow_fill are ever read.
	// ------------------------------------------------------------------
	logic [VAL_W-1:0] shadow_tbl [TBL_DEPTH];
	int unsigned      shadow_fill = 0;

	// Applies one request to the shadow table and returns the result the
	// block must give for it.
	function automatic rsp_item_t apply_table_op(req_item_t item);
		rsp_item_t   res;
		int unsigned k;
		res = '0;
		if (item.command == CMD_INSERT) begin
			if (shadow_fill >= TBL_DEPTH) begin
				// full table: refused, table untouched
				res.status = 1'b1;
			end else begin
				// walk down from the top, moving larger entries up; equal
				// entries stay below the new value
				k = shadow_fill;
				while (k > 0 && shadow_tbl[k-1] > item.value) begin
					shadow_tbl[k] = shadow_tbl[k-1];
					k--;
				end
				shadow_tbl[k] = item.value;
				shadow_fill++;
				res.index = k[IDX_W-1:0];
			end
		end else begin
			// first filled entry not below the key; a hit there is the lowest equal one
			k = 0;
			while (k < shadow_fill && shadow_tbl[k] < item.value)
				k++;
			if (k < shadow_fill && shadow_tbl[k] == item.value) begin
				res.found = 1'b1;
				res.index = k[IDX_W-1:0];
			end
		end
		res.entries_used = shadow_fill[USED_W-1:0];
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Shared bookkeeping
	// ------------------------------------------------------------------
	stim_t       pending_q [$];
	rsp_item_t   expected_rsp_q [$];
	int unsigned n_total    = 0;
	int unsigned n_accepted = 0;
	int unsigned n_checked  = 0;
	int unsigned err_cnt    = 0;

	// Idle-free stretches: every third block of 128 transfers, and the tail.
	function automatic bit calm_phase();
		return (n_accepted + CALM_TAIL >= n_total) || ((n_accepted / 128) % 3 == 2);
	endfunction

	// Value mix: a narrow band to get duplicates, the range ends, full random.
	function automatic logic [VAL_W-1:0] pick_value();
		logic [VAL_W-1:0] v;
		case ($urandom_range(0, 3))
			0: v = VAL_W'($urandom_range(0, 15));
			1: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = '1;
					2: v = VAL_W'(1);
					default: v = VAL_W'((1 << VAL_W) - 2);
				endcase
			end
			default: v = VAL_W'($urandom_range(0, (1 << VAL_W) - 1));
		endcase
		return v;
	endfunction

	// ------------------------------------------------------------------
	// Request driver: holds valid until the transfer, idles in bursts,
	// and honors drain points from the stimulus queue.
	// ------------------------------------------------------------------
	int unsigned gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
			gap_left = 0;
		end else begin
			if (req_valid_q && req_if.ready) begin
				expected_rsp_q.push_back(apply_table_op(req_data_q));
				n_accepted++;
			end
			if (req_valid_q && !req_if.ready) begin
				// still waiting on this transfer: hold everything
				req_valid_q <= 1'b1;
			end else if (gap_left != 0) begin
				gap_left--;
				req_valid_q <= 1'b0;
			end else if (pending_q.size() == 0) begin
				req_valid_q <= 1'b0;
			end else if (pending_q[0].drain_first && expected_rsp_q.size() != 0) begin
				// sender pause: let the block run dry first
				req_valid_q <= 1'b0;
			end else if (!calm_phase() && $urandom_range(0, 5) == 0) begin
				gap_left = $urandom_range(1, 17) - 1;
				req_valid_q <= 1'b0;
			end else begin
				req_valid_q <= 1'b1;
				req_data_q  <= pending_q[0].item;
				void'(pending_q.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------
	// Result side: random stall bursts on ready, and the checker.
	// ------------------------------------------------------------------
	int unsigned stall_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready_q <= 1'b0;
			stall_left = 0;
		end else if (stall_left != 0) begin
			stall_left--;
			rsp_ready_q <= 1'b0;
		end else if (!calm_phase() && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 17) - 1;
			rsp_ready_q <= 1'b0;
		end else begin
			rsp_ready_q <= 1'b1;
		end
	end

	rsp_item_t want;

	always @(posedge clk) begin
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_rsp_q.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS) begin
					$write("%0t: result with nothing pending: ", $realtime);
					$display("found=%0b index=%0d status=%0b used=%0d",
						rsp_if.data.found, rsp_if.data.index,
						rsp_if.data.status, rsp_if.data.entries_used);
				end
			end else begin
				want = expected_rsp_q.pop_front();
				if (rsp_if.data.found !== want.found || rsp_if.data.index !== want.index ||
						rsp_if.data.status !== want.status ||
						rsp_if.data.entries_used !== want.entries_used) begin
					err_cnt++;
					if (err_cnt <= MAX_REPORTS) begin
						$write("%0t: result %0d mismatch: ", $realtime, n_checked);
						$write("expected found=%0b index=%0d status=%0b used=%0d, ",
							want.found, want.index, want.status, want.entries_used);
						$display("got found=%0b index=%0d status=%0b used=%0d",
							rsp_if.data.found, rsp_if.data.index,
							rsp_if.data.status, rsp_if.data.entries_used);
					end
				end
			end
			n_checked++;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus, reset and end of run
	// ------------------------------------------------------------------
	task automatic queue_op(cmd_t cmd, logic [VAL_W-1:0] val, bit drain);
		stim_t s;
		s.item.command = cmd;
		s.item.value   = val;
		s.drain_first  = drain;
		pending_q.push_back(s);
	endtask

	initial begin
		logic [VAL_W-1:0] known_vals [$];
		logic [VAL_W-1:0] v;
		int unsigned      n_ins;
		int unsigned      ins_pct;
		bit               drain;

		// Directed: searches on an empty table, range ends, equal values
		// landing after their twins, lowest-equal hits and misses.
		queue_op(CMD_SEARCH, 10'd0, 1'b0);
		queue_op(CMD_SEARCH, 10'd1023, 1'b0);
		queue_op(CMD_INSERT, 10'd512, 1'b0);
		queue_op(CMD_INSERT, 10'd0, 1'b0);
		queue_op(CMD_INSERT, 10'd1023, 1'b0);
		queue_op(CMD_INSERT, 10'd1023, 1'b0);
		queue_op(CMD_INSERT, 10'd0, 1'b0);
		queue_op(CMD_INSERT, 10'd512, 1'b0);
		queue_op(CMD_SEARCH, 10'd0, 1'b0);
		queue_op(CMD_SEARCH, 10'd512, 1'b0);
		queue_op(CMD_SEARCH, 10'd1023, 1'b0);
		queue_op(CMD_SEARCH, 10'd511, 1'b0);
		queue_op(CMD_SEARCH, 10'd1, 1'b0);
		queue_op(CMD_INSERT, 10'd341, 1'b0);
		queue_op(CMD_INSERT, 10'd682, 1'b0);
		queue_op(CMD_SEARCH, 10'd341, 1'b0);
		queue_op(CMD_SEARCH, 10'd682, 1'b0);
		queue_op(CMD_SEARCH, 10'd1022, 1'b0);
		known_vals = '{10'd512, 10'd0, 10'd1023, 10'd341, 10'd682};
		n_ins = 8;

		// Random: the table only ever grows, so inserts stay sparse while it
		// fills slowly under lots of searches, then speed up to fill it and
		// keep knocking on the full table. Half the searches aim at a stored value.
		for (int i = 0; i < RAND_ITEMS; i++) begin
			ins_pct = (i < 1000) ? 8 : 40;
			drain = (i == 0 || i == 450 || i == 1100);
			if ($urandom_range(0, 99) < ins_pct) begin
				v = pick_value();
				if (n_ins < TBL_DEPTH)
					known_vals.push_back(v);
				n_ins++;
				queue_op(CMD_INSERT, v, drain);
			end else begin
				if ($urandom_range(0, 1) == 1)
					v = known_vals[$urandom_range(0, known_vals.size() - 1)];
				else
					v = pick_value();
				queue_op(CMD_SEARCH, v, drain);
			end
		end
		n_total = pending_q.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted < n_total)
			@(posedge clk);
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (err_cnt == 0 && expected_rsp_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Watchdog: stops a hung run and reports it as failed.
	initial begin
		#5_000_000;
		$display("timeout: %0d of %0d accepted, %0d results pending",
			n_accepted, n_total, expected_rsp_q.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
